@@ src/klr_pkg.sv @@
package klr_pkg;

    localparam int NUM_LAYERS = 4;
    localparam int KEY_CODES  = 1024;

    localparam int CODE_W    = 10;
    localparam int VAL_W     = 2;
    localparam int TLAYER_W  = 2;
    localparam int LAYER_W   = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 10;
    localparam int ENT_W     = 1 + 2 * CODE_W;

    localparam int MAX_OUT = 64;
    localparam int N_W     = $clog2(MAX_OUT + 1);

    // down-key bitmap, stored as words
    localparam int WORD_W = 32;
    localparam int BIT_W  = $clog2(WORD_W);
    localparam int NWORDS = (KEY_CODES + WORD_W - 1) / WORD_W;
    localparam int WA_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int CNT_W  = $clog2(KEY_CODES + 1);

    // mapping table
    localparam int TDEPTH = NUM_LAYERS * KEY_CODES;
    localparam int TA_W   = $clog2(TDEPTH);

    localparam logic FUNC_KEY = 1'b0;
    localparam logic FUNC_TBL = 1'b1;

    localparam logic [VAL_W-1:0] VAL_REL = 2'd0;
    localparam logic [VAL_W-1:0] VAL_PRS = 2'd1;
    localparam logic [VAL_W-1:0] VAL_REP = 2'd2;
    localparam logic [VAL_W-1:0] VAL_BAD = 2'd3;

    typedef struct packed {
        logic ready;
        logic clr_step;
        logic plan;
        logic ev_rd;
        logic ev_emit;
        logic scan_rd;
        logic scan_emit;
        logic scan_wb;
        logic fix_rd;
        logic fix_wr;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic in_fire;
        logic work;
        logic prel;
        logic tap;
        logic nev_zero;
        logic ev_last;
        logic out_free;
        logic word_nz;
        logic n_full;
        logic cnt_zero;
        logic w_last;
    } t_sts;

    function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] w);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (w[b]) begin
                idx = BIT_W'(b);
            end
        end
        return idx;
    endfunction

    function automatic logic tracked(input logic [CODE_W-1:0] c);
        return {1'b0, c} < (CODE_W + 1)'(KEY_CODES);
    endfunction

endpackage

@@ src/klr_in_if.sv @@
interface klr_in_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [klr_pkg::CODE_W-1:0]    key_code;
    logic [klr_pkg::VAL_W-1:0]     key_value;
    logic [klr_pkg::TLAYER_W-1:0]  table_layer;
    logic                          entry_valid;
    logic [klr_pkg::CODE_W-1:0]    target_key;
    logic [klr_pkg::CODE_W-1:0]    target_mod;

    modport source (output valid, func, key_code, key_value, table_layer, entry_valid,
                    target_key, target_mod, input ready);
    modport sink   (input valid, func, key_code, key_value, table_layer, entry_valid,
                    target_key, target_mod, output ready);
endinterface

@@ src/klr_out_if.sv @@
interface klr_out_if;
    logic                        valid;
    logic                        ready;
    logic [klr_pkg::CODE_W-1:0]  out_code;
    logic [klr_pkg::VAL_W-1:0]   out_value;
    logic                        last_of_run;

    modport source (output valid, out_code, out_value, last_of_run, input ready);
    modport sink   (input valid, out_code, out_value, last_of_run, output ready);
endinterface

@@ src/klr_ctrl.sv @@
module klr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  klr_pkg::t_sts i_sts,
    output klr_pkg::t_cmd o_cmd
);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_PLAN = 4'd2;
    localparam logic [3:0] S_EVRD = 4'd3;
    localparam logic [3:0] S_EVEM = 4'd4;
    localparam logic [3:0] S_SRD  = 4'd5;
    localparam logic [3:0] S_SCAN = 4'd6;
    localparam logic [3:0] S_FXRD = 4'd7;
    localparam logic [3:0] S_FXWR = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic [3:0] fin_state;

    assign fin_state = i_sts.tap ? S_FXRD : S_IDLE;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.ready = 1'b1;
                if (i_sts.in_fire && i_sts.work) begin
                    n_state = S_PLAN;
                end
            end
            S_PLAN: begin
                o_cmd.plan = 1'b1;
                n_state    = S_EVRD;
            end
            S_EVRD: begin
                if (i_sts.nev_zero) begin
                    n_state = i_sts.prel ? S_SRD : S_IDLE;
                end else begin
                    o_cmd.ev_rd = 1'b1;
                    n_state     = S_EVEM;
                end
            end
            S_EVEM: begin
                if (i_sts.out_free) begin
                    o_cmd.ev_emit = 1'b1;
                    if (i_sts.ev_last) begin
                        n_state = i_sts.prel ? S_SRD : S_IDLE;
                    end else begin
                        n_state = S_EVRD;
                    end
                end
            end
            S_SRD: begin
                if (i_sts.cnt_zero) begin
                    n_state = fin_state;
                end else begin
                    o_cmd.scan_rd = 1'b1;
                    n_state       = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.n_full) begin
                    o_cmd.scan_wb = 1'b1;
                    n_state       = fin_state;
                end else if (i_sts.word_nz) begin
                    if (i_sts.out_free) begin
                        o_cmd.scan_emit = 1'b1;
                    end
                end else begin
                    o_cmd.scan_wb = 1'b1;
                    n_state = (i_sts.w_last || i_sts.cnt_zero) ? fin_state : S_SRD;
                end
            end
            S_FXRD: begin
                o_cmd.fix_rd = 1'b1;
                n_state      = S_FXWR;
            end
            S_FXWR: begin
                o_cmd.fix_wr = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ src/klr_dp.sv @@
module klr_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    klr_in_if.sink                         i_in,
    klr_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [klr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [klr_pkg::CFG_W-1:0]      i_cfg_data,
    input  klr_pkg::t_cmd                  i_cmd,
    output klr_pkg::t_sts                  o_sts
);

    localparam int NL  = klr_pkg::NUM_LAYERS;
    localparam int LW  = klr_pkg::LAYER_W;
    localparam int CW  = klr_pkg::CODE_W;
    localparam int VW  = klr_pkg::VAL_W;
    localparam int BW  = klr_pkg::BIT_W;
    localparam int WW  = klr_pkg::WORD_W;
    localparam int WAW = klr_pkg::WA_W;
    localparam int TAW = klr_pkg::TA_W;
    localparam int EW  = klr_pkg::ENT_W;
    localparam int NW  = klr_pkg::N_W;
    localparam int KW  = klr_pkg::CNT_W;

    // config and layer flags
    logic [CW-1:0] r_pfx [NL];
    logic [NL-1:0] r_act_f, r_used, r_wr;
    logic [KW-1:0] r_cnt, n_cnt;

    // current item
    logic [CW-1:0] r_code;
    logic [VW-1:0] r_val;
    logic [LW-1:0] r_act;
    logic          r_prel, r_map, r_tap, r_upd;

    // planned events
    logic [CW-1:0] r_ev_code [3];
    logic [VW-1:0] r_ev_val  [3];
    logic [1:0]    r_nev, r_i;
    logic [CW-1:0] n_ev_code [3];
    logic [VW-1:0] n_ev_val  [3];
    logic [1:0]    n_nev;

    logic [NW-1:0]  r_n;
    logic [WAW-1:0] r_w;

    // memories
    logic [EW-1:0]  tbl_mem [klr_pkg::TDEPTH];
    logic [EW-1:0]  r_tbl_rd;
    logic [TAW-1:0] r_clr;
    logic           r_clr_done;
    logic [WW-1:0]  bm_mem [klr_pkg::NWORDS];
    logic [klr_pkg::NWORDS-1:0] r_rowv;
    logic [WW-1:0]  r_bm_rd;

    // output register
    logic          r_ovalid, r_olast;
    logic [CW-1:0] r_ocode;
    logic [VW-1:0] r_oval;

    // decode
    logic [NL-1:0] exist;
    logic          act_v, lay_v;
    logic [LW-1:0] act_idx, lay_idx;
    logic [CW-1:0] best_pfx;
    logic          in_fire, ev_ok, c_prel, c_actv, c_rep;
    logic          tbl_wr_ok;
    logic [TAW-1:0] tbl_ra, tbl_wa;
    logic [EW-1:0]  tbl_wd;
    logic           tbl_we;

    // bitmap access
    logic [CW-1:0]  ev_code;
    logic [VW-1:0]  ev_val;
    logic           ev_upd;
    logic [BW-1:0]  ev_bit, fx_bit, sc_bit;
    logic [WAW-1:0] bm_ra, bm_wa;
    logic [WW-1:0]  bm_wd;
    logic           bm_we, bm_re;
    logic           out_free, ld;
    logic [CW-1:0]  ld_code;
    logic [VW-1:0]  ld_val;
    logic           ld_last;

    always_comb begin
        exist    = '0;
        act_v    = 1'b0;
        act_idx  = '0;
        best_pfx = '0;
        lay_v    = 1'b0;
        lay_idx  = '0;
        for (int i = 0; i < NL; i++) begin
            exist[i] = (r_pfx[i] != '0);
            for (int j = 0; j < i; j++) begin
                if (r_pfx[j] == r_pfx[i]) begin
                    exist[i] = 1'b0;
                end
            end
        end
        for (int i = 0; i < NL; i++) begin
            if (r_act_f[i] && exist[i] && (!act_v || r_pfx[i] < best_pfx)) begin
                act_v    = 1'b1;
                act_idx  = LW'(i);
                best_pfx = r_pfx[i];
            end
        end
        for (int i = NL - 1; i >= 0; i--) begin
            if (i_in.key_code != '0 && r_pfx[i] == i_in.key_code) begin
                lay_v   = 1'b1;
                lay_idx = LW'(i);
            end
        end
    end

    assign in_fire = i_in.valid && i_cmd.ready;
    assign ev_ok   = (i_in.func == klr_pkg::FUNC_KEY) && (i_in.key_value != klr_pkg::VAL_BAD)
                     && klr_pkg::tracked(i_in.key_code);
    assign c_prel  = act_v && (i_in.key_value == klr_pkg::VAL_REL)
                     && (best_pfx == i_in.key_code);
    assign c_actv  = !act_v && (i_in.key_value == klr_pkg::VAL_PRS) && lay_v
                     && (r_cnt == '0);
    assign c_rep   = (i_in.key_value == klr_pkg::VAL_REP) && lay_v;

    assign tbl_wr_ok = (i_in.func == klr_pkg::FUNC_TBL) && klr_pkg::tracked(i_in.key_code)
                       && ({2'b0, i_in.table_layer} < 4'(NL));
    assign tbl_ra = TAW'(act_idx * klr_pkg::KEY_CODES) + TAW'(i_in.key_code);
    assign tbl_we = i_cmd.clr_step || (in_fire && tbl_wr_ok);
    assign tbl_wa = i_cmd.clr_step ? r_clr
                    : TAW'(i_in.table_layer * klr_pkg::KEY_CODES) + TAW'(i_in.key_code);
    assign tbl_wd = (i_cmd.clr_step || !i_in.entry_valid) ? '0
                    : {1'b1, i_in.target_key, i_in.target_mod};

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            tbl_mem[tbl_wa] <= tbl_wd;
        end
        if (in_fire) begin
            r_tbl_rd <= tbl_mem[tbl_ra];
        end
    end

    // plan the events of a key item
    always_comb begin
        logic          e_v;
        logic [CW-1:0] e_tgt, e_mod;
        logic [1:0]    k;
        e_v   = r_tbl_rd[EW-1];
        e_tgt = r_tbl_rd[2*CW-1:CW];
        e_mod = r_tbl_rd[CW-1:0];
        k     = 2'd0;
        for (int i = 0; i < 3; i++) begin
            n_ev_code[i] = r_code;
            n_ev_val[i]  = r_val;
        end
        n_nev = 2'd1;
        if (r_prel) begin
            n_ev_val[0] = klr_pkg::VAL_PRS;
            n_ev_val[1] = klr_pkg::VAL_REL;
            n_nev       = r_tap ? 2'd2 : 2'd0;
        end else if (r_map && e_v) begin
            if (e_mod != '0 && r_val == klr_pkg::VAL_PRS) begin
                n_ev_code[k] = e_mod;
                n_ev_val[k]  = klr_pkg::VAL_PRS;
                k            = k + 2'd1;
            end
            n_ev_code[k] = e_tgt;
            n_ev_val[k]  = r_val;
            k            = k + 2'd1;
            if (e_mod != '0 && r_val == klr_pkg::VAL_REL) begin
                n_ev_code[k] = e_mod;
                n_ev_val[k]  = klr_pkg::VAL_REL;
                k            = k + 2'd1;
            end
            n_nev = k;
        end else if (r_map && !r_used[r_act] && r_val == klr_pkg::VAL_PRS) begin
            // unmapped first press flushes the prefix tap
            n_ev_code[0] = r_pfx[r_act];
            n_ev_val[0]  = klr_pkg::VAL_PRS;
            n_ev_code[1] = r_pfx[r_act];
            n_ev_val[1]  = klr_pkg::VAL_REL;
            n_nev        = 2'd3;
        end
    end

    assign ev_code = r_ev_code[r_i];
    assign ev_val  = r_ev_val[r_i];
    assign ev_upd  = r_upd && klr_pkg::tracked(ev_code);
    assign ev_bit  = ev_code[BW-1:0];
    assign fx_bit  = r_code[BW-1:0];
    assign sc_bit  = klr_pkg::lowest_set(r_bm_rd);

    assign bm_re = i_cmd.ev_rd || i_cmd.scan_rd || i_cmd.fix_rd;
    assign bm_ra = i_cmd.scan_rd ? r_w
                   : i_cmd.fix_rd ? WAW'(r_code >> BW) : WAW'(ev_code >> BW);
    assign bm_we = (i_cmd.ev_emit && ev_upd) || i_cmd.scan_wb || i_cmd.fix_wr;

    always_comb begin
        bm_wa = r_w;
        bm_wd = r_bm_rd;
        if (i_cmd.ev_emit) begin
            bm_wa         = WAW'(ev_code >> BW);
            bm_wd[ev_bit] = (ev_val != klr_pkg::VAL_REL);
        end else if (i_cmd.fix_wr) begin
            bm_wa         = WAW'(r_code >> BW);
            bm_wd[fx_bit] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (bm_we) begin
            bm_mem[bm_wa] <= bm_wd;
        end
        if (bm_re) begin
            r_bm_rd <= r_rowv[bm_ra] ? bm_mem[bm_ra] : '0;
        end else if (i_cmd.scan_emit) begin
            r_bm_rd[sc_bit] <= 1'b0;
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (i_cmd.ev_emit && ev_upd) begin
            if (ev_val != klr_pkg::VAL_REL && !r_bm_rd[ev_bit]) begin
                n_cnt = r_cnt + KW'(1);
            end else if (ev_val == klr_pkg::VAL_REL && r_bm_rd[ev_bit]) begin
                n_cnt = r_cnt - KW'(1);
            end
        end else if (i_cmd.scan_emit) begin
            n_cnt = r_cnt - KW'(1);
        end else if (i_cmd.fix_wr && r_bm_rd[fx_bit]) begin
            n_cnt = r_cnt - KW'(1);
        end
    end

    assign out_free = !r_ovalid || o_out.ready;
    assign ld       = i_cmd.ev_emit || i_cmd.scan_emit;
    assign ld_code  = i_cmd.scan_emit ? CW'({r_w, sc_bit}) : ev_code;
    assign ld_val   = i_cmd.scan_emit ? klr_pkg::VAL_REL : ev_val;
    assign ld_last  = i_cmd.scan_emit
                      ? ((r_cnt == KW'(1)) || (r_n == NW'(klr_pkg::MAX_OUT - 1)))
                      : (o_sts.ev_last && (!r_prel || r_cnt == '0));

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NL; i++) begin
                r_pfx[i] <= '0;
            end
            r_act_f    <= '0;
            r_used     <= '0;
            r_wr       <= '0;
            r_cnt      <= '0;
            r_rowv     <= '0;
            r_clr      <= '0;
            r_clr_done <= 1'b0;
            r_ovalid   <= 1'b0;
            r_prel     <= 1'b0;
            r_map      <= 1'b0;
            r_tap      <= 1'b0;
            r_nev      <= '0;
            r_i        <= '0;
            r_n        <= '0;
            r_w        <= '0;
        end else begin
            if (i_cfg_we && ({1'b0, i_cfg_idx} < (klr_pkg::CFG_IDX_W + 1)'(NL))) begin
                r_pfx[LW'(i_cfg_idx)] <= i_cfg_data;
            end
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + TAW'(1);
                if (r_clr == TAW'(klr_pkg::TDEPTH - 1)) begin
                    r_clr_done <= 1'b1;
                end
            end
            if (in_fire && ev_ok) begin
                r_prel <= c_prel;
                r_map  <= act_v && !c_prel && !c_actv && !c_rep;
                r_tap  <= c_prel && !r_used[act_idx] && !r_wr[act_idx];
                if (c_prel) begin
                    r_act_f[act_idx] <= 1'b0;
                end else if (c_actv) begin
                    r_act_f[lay_idx] <= 1'b1;
                    r_used[lay_idx]  <= 1'b0;
                    r_wr[lay_idx]    <= 1'b0;
                end else if (c_rep) begin
                    r_used[lay_idx] <= 1'b1;
                end
            end
            if (i_cmd.plan) begin
                r_nev <= n_nev;
                r_i   <= '0;
                r_n   <= '0;
                r_w   <= '0;
                if (r_map) begin
                    if (!r_tbl_rd[EW-1] && !r_used[r_act] && r_val == klr_pkg::VAL_PRS) begin
                        r_wr[r_act] <= 1'b1;
                    end
                    if (r_val == klr_pkg::VAL_PRS) begin
                        r_used[r_act] <= 1'b1;
                    end
                end
            end
            if (i_cmd.ev_emit) begin
                r_i <= r_i + 2'd1;
            end
            if (ld) begin
                r_n <= r_n + NW'(1);
            end
            if (i_cmd.scan_wb) begin
                r_w <= r_w + WAW'(1);
            end
            if (bm_we) begin
                r_rowv[bm_wa] <= 1'b1;
            end
            r_cnt <= n_cnt;
            if (ld) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_code <= i_in.key_code;
            r_val  <= i_in.key_value;
            r_act  <= act_idx;
        end
        if (i_cmd.plan) begin
            r_upd <= !r_prel;
            for (int i = 0; i < 3; i++) begin
                r_ev_code[i] <= n_ev_code[i];
                r_ev_val[i]  <= n_ev_val[i];
            end
        end
        if (ld) begin
            r_ocode <= ld_code;
            r_oval  <= ld_val;
            r_olast <= ld_last;
        end
    end

    assign i_in.ready        = i_cmd.ready;
    assign o_out.valid       = r_ovalid;
    assign o_out.out_code    = r_ocode;
    assign o_out.out_value   = r_oval;
    assign o_out.last_of_run = r_olast;

    assign o_sts.clr_done = r_clr_done;
    assign o_sts.in_fire  = in_fire;
    assign o_sts.work     = ev_ok && (c_prel || (!c_actv && !c_rep));
    assign o_sts.prel     = r_prel;
    assign o_sts.tap      = r_tap;
    assign o_sts.nev_zero = (r_nev == 2'd0);
    assign o_sts.ev_last  = (r_i == r_nev - 2'd1);
    assign o_sts.out_free = out_free;
    assign o_sts.word_nz  = (r_bm_rd != '0);
    assign o_sts.n_full   = (r_n == NW'(klr_pkg::MAX_OUT));
    assign o_sts.cnt_zero = (r_cnt == '0);
    assign o_sts.w_last   = (r_w == WAW'(klr_pkg::NWORDS - 1));

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= KW'(klr_pkg::KEY_CODES))
        else $error("down count out of range");
    a_no_fire_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |-> r_clr_done)
        else $error("item taken during table clear");
    a_n_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= NW'(klr_pkg::MAX_OUT))
        else $error("result count beyond limit");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ld |-> out_free)
        else $error("output register overwritten");

endmodule

@@ src/key_layer_remapper.sv @@
// Channel   Dir  Beat contents
// i_in      in   func, key_code, key_value, table_layer, entry_valid, target_key, target_mod
// o_out     out  out_code, out_value, last_of_run
// i_cfg_*   in   we / idx / data, prefix_key_0..3 (no handshake)
//
// After reset the mapping table is cleared one entry per cycle, all layers x key codes
// entries, with i_in.ready low; config writes are taken meanwhile.
// One item at a time. Table writes and swallowed events are taken in the idle state; a
// plain key event is planned, then each emitted beat reads its bitmap word and writes it back.
// A prefix release scans the down-key bitmap one 32-bit word per pass: each word is read,
// then its set keys are released one per beat, up to 64 beats.
// A stalled o_out holds the output register; the sequencer waits on it.
module key_layer_remapper (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    klr_in_if.sink                         i_in,
    klr_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [klr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [klr_pkg::CFG_W-1:0]      i_cfg_data
);

    klr_pkg::t_cmd cmd;
    klr_pkg::t_sts sts;

    // sequencer: clear pass, item plan, beat emission, release scan, tap bitmap fix-up
    klr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // layer flags, mapping table, down-key bitmap, output register
    klr_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sts      (sts)
    );

endmodule

@@ dv/key_layer_remapper_checker.sv @@
`timescale 1ns / 100ps

module key_layer_remapper_checker
    import klr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    klr_in_if                     in_ch,
    klr_out_if                    out_ch,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data,
    output int                    o_fails,
    output int                    o_pending,
    output int                    o_beats
);

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [VAL_W-1:0]  value;
        logic              last;
    } t_key_beat;

    t_key_beat             expected_beats[$];
    t_key_beat             run_beats[$];
    logic [CODE_W-1:0]     prefix_key [NUM_LAYERS];
    logic [KEY_CODES-1:0]  keys_down;
    logic [NUM_LAYERS-1:0] layer_on, layer_used, layer_written;
    logic [ENT_W-1:0]      remap [TDEPTH];
    int                    fails, beats;

    function automatic int layer_owning(input logic [CODE_W-1:0] c);
        if (c == '0) begin
            return -1;
        end
        for (int i = 0; i < NUM_LAYERS; i++) begin
            if (prefix_key[i] == c) begin
                return i;
            end
        end
        return -1;
    endfunction

    // lowest prefix code wins among live, non-shadowed layers
    function automatic int current_layer();
        int best;
        best = -1;
        for (int i = 0; i < NUM_LAYERS; i++) begin
            if (layer_on[i] && prefix_key[i] != '0 && layer_owning(prefix_key[i]) == i) begin
                if (best < 0 || prefix_key[i] < prefix_key[best]) begin
                    best = i;
                end
            end
        end
        return best;
    endfunction

    task automatic emit(input logic [CODE_W-1:0] c, input logic [VAL_W-1:0] v);
        t_key_beat b;
        b.code  = c;
        b.value = v;
        b.last  = 1'b0;
        if (run_beats.size() < MAX_OUT) begin
            run_beats.insert(run_beats.size(), b);
        end
    endtask

    task automatic predict_remap();
        logic [CODE_W-1:0] c, tgt, md;
        logic [VAL_W-1:0]  v;
        logic [ENT_W-1:0]  ent;
        int                act, lay;
        c = in_ch.key_code;
        v = in_ch.key_value;
        run_beats.delete();
        if (in_ch.func == FUNC_TBL) begin
            remap[int'(in_ch.table_layer) * KEY_CODES + int'(c)] =
                in_ch.entry_valid ? {1'b1, in_ch.target_key, in_ch.target_mod} : '0;
            return;
        end
        if (v == VAL_BAD) begin
            return;
        end
        act = current_layer();
        lay = layer_owning(c);
        if (act >= 0 && v == VAL_REL && prefix_key[act] == c) begin
            layer_on[act] = 1'b0;
            if (!layer_used[act] && !layer_written[act]) begin
                emit(c, VAL_PRS);
                emit(c, VAL_REL);
            end
            // listing uses the bitmap as it was before this beat's tap
            for (int k = 0; k < KEY_CODES; k++) begin
                if (keys_down[k]) begin
                    emit(CODE_W'(k), VAL_REL);
                end
            end
        end else if (act < 0 && v == VAL_PRS && lay >= 0 && keys_down == '0) begin
            layer_on[lay]      = 1'b1;
            layer_used[lay]    = 1'b0;
            layer_written[lay] = 1'b0;
            return;
        end else if (v == VAL_REP && lay >= 0) begin
            layer_used[lay] = 1'b1;
            return;
        end else if (act >= 0) begin
            ent = remap[act * KEY_CODES + int'(c)];
            if (ent[ENT_W-1]) begin
                tgt = ent[2*CODE_W-1:CODE_W];
                md  = ent[CODE_W-1:0];
                if (md != '0 && v == VAL_PRS) begin
                    emit(md, VAL_PRS);
                end
                emit(tgt, v);
                if (md != '0 && v == VAL_REL) begin
                    emit(md, VAL_REL);
                end
            end else begin
                if (!layer_used[act] && v == VAL_PRS) begin
                    emit(prefix_key[act], VAL_PRS);
                    emit(prefix_key[act], VAL_REL);
                    layer_written[act] = 1'b1;
                end
                emit(c, v);
            end
            if (v == VAL_PRS) begin
                layer_used[act] = 1'b1;
            end
        end else begin
            emit(c, v);
        end
        foreach (run_beats[i]) begin
            keys_down[run_beats[i].code] = (run_beats[i].value != VAL_REL);
        end
        if (run_beats.size() > 0) begin
            run_beats[run_beats.size()-1].last = 1'b1;
        end
        foreach (run_beats[i]) begin
            expected_beats.insert(expected_beats.size(), run_beats[i]);
        end
    endtask

    always @(posedge i_clk) begin
        t_key_beat want;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LAYERS; i++) begin
                prefix_key[i] = '0;
            end
            for (int i = 0; i < TDEPTH; i++) begin
                remap[i] = '0;
            end
            keys_down     = '0;
            layer_on      = '0;
            layer_used    = '0;
            layer_written = '0;
            expected_beats.delete();
            fails = 0;
            beats = 0;
        end else begin
            if (i_cfg_we && int'(i_cfg_idx) < NUM_LAYERS) begin
                prefix_key[i_cfg_idx] = i_cfg_data;
            end
            if (out_ch.valid && out_ch.ready) begin
                beats++;
                if (expected_beats.size() == 0) begin
                    $error("unexpected beat: code %0d value %0d", out_ch.out_code,
                           out_ch.out_value);
                    fails++;
                end else begin
                    want = expected_beats.pop_front();
                    if (out_ch.out_code !== want.code) begin
                        $error("out_code: expected %0d, got %0d", want.code, out_ch.out_code);
                        fails++;
                    end
                    if (out_ch.out_value !== want.value) begin
                        $error("out_value: expected %0d, got %0d", want.value,
                               out_ch.out_value);
                        fails++;
                    end
                    if (out_ch.last_of_run !== want.last) begin
                        $error("last_of_run: expected %0d, got %0d", want.last,
                               out_ch.last_of_run);
                        fails++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                predict_remap();
            end
        end
        o_fails   <= fails;
        o_pending <= expected_beats.size();
        o_beats   <= beats;
    end

endmodule

@@ dv/key_layer_remapper_test.sv @@
`timescale 1ns / 100ps

module key_layer_remapper_test;
    import klr_pkg::*;

    // register map of the config port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PREFIX_0,
        REG_PREFIX_1,
        REG_PREFIX_2,
        REG_PREFIX_3
    } t_prefix_reg;

    typedef struct packed {
        logic              func;
        logic [CODE_W-1:0] code;
        logic [VAL_W-1:0]  value;
        logic [1:0]        layer;
        logic              mapped;
        logic [CODE_W-1:0] tgt;
        logic [CODE_W-1:0] md;
    } t_key_item;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_WAIT  = 250;   // worst release scan plus margin

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_W-1:0]      cfg_data;
    int                    fails, pending, beats;
    int                    items_sent;
    int                    cycles;
    logic                  send_quiet, recv_quiet;
    logic                  long_hold_req;
    logic [CODE_W-1:0]     prefixes [NUM_LAYERS];

    klr_in_if  in_ch ();
    klr_out_if out_ch ();

    key_layer_remapper uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    key_layer_remapper_checker chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_fails    (fails),
        .o_pending  (pending),
        .o_beats    (beats)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #6 i_clk = ~i_clk;
        end
    end

    // watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // gap lengths: mostly none or short, now and then a long one
    function automatic int pick_gap(input logic quiet);
        int r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // output side: random stalls, plus one long hold-off on request
    initial begin
        int hold_left;
        out_ch.ready = 1'b0;
        recv_quiet   = 1'b0;
        hold_left    = 0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 199) == 0) begin
                recv_quiet = ~recv_quiet;
            end
            if (hold_left > 0) begin
                out_ch.ready = 1'b0;
                hold_left--;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = 600;
                out_ch.ready  = 1'b0;
            end else begin
                hold_left    = pick_gap(recv_quiet);
                out_ch.ready = (hold_left == 0);
                if (hold_left > 0) begin
                    hold_left--;
                end
            end
        end
    end

    // one beat on the input channel; returns at the accepting edge
    task automatic send(input t_key_item it);
        int gap;
        gap = pick_gap(send_quiet);
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.func        = it.func;
        in_ch.key_code    = it.code;
        in_ch.key_value   = it.value;
        in_ch.table_layer = it.layer;
        in_ch.entry_valid = it.mapped;
        in_ch.target_key  = it.tgt;
        in_ch.target_mod  = it.md;
        in_ch.valid       = 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    task automatic key(input logic [CODE_W-1:0] c, input logic [VAL_W-1:0] v);
        t_key_item it;
        it       = '0;
        it.func  = FUNC_KEY;
        it.code  = c;
        it.value = v;
        send(it);
    endtask

    task automatic map_key(input logic [1:0] l, input logic [CODE_W-1:0] src,
                           input logic on, input logic [CODE_W-1:0] tgt,
                           input logic [CODE_W-1:0] md);
        t_key_item it;
        it        = '0;
        it.func   = FUNC_TBL;
        it.code   = src;
        it.value  = VAL_W'($urandom_range(0, 3));
        it.layer  = l;
        it.mapped = on;
        it.tgt    = tgt;
        it.md     = md;
        send(it);
    endtask

    task automatic set_prefix(input t_prefix_reg r, input logic [CODE_W-1:0] c);
        @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_idx  = r;
        cfg_data = c;
        prefixes[r] = c;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    // idle the input, let every expected beat arrive, then cover silent work
    task automatic drain();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // mostly the small mapped pool and the live prefixes, sometimes anything
    function automatic logic [CODE_W-1:0] pick_code();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            return CODE_W'(40 + $urandom_range(0, 7));
        end else if (r < 8) begin
            return prefixes[$urandom_range(0, NUM_LAYERS - 1)];
        end else if (r == 8) begin
            return CODE_W'($urandom_range(0, KEY_CODES - 1));
        end
        return $urandom_range(0, 1) ? CODE_W'(KEY_CODES - 1) : '0;
    endfunction

    task automatic random_map();
        map_key(2'($urandom_range(0, 3)), pick_code(), $urandom_range(0, 3) != 0,
                $urandom_range(0, 2) == 0 ? CODE_W'($urandom_range(0, KEY_CODES - 1))
                                          : CODE_W'(60 + $urandom_range(0, 7)),
                $urandom_range(0, 1) ? '0 : CODE_W'($urandom_range(0, KEY_CODES - 1)));
    endtask

    // stray item with random fields
    task automatic random_noise();
        t_key_item it;
        it.func   = ($urandom_range(0, 3) == 0) ? FUNC_TBL : FUNC_KEY;
        it.code   = ($urandom_range(0, 1)) ? pick_code() : CODE_W'($urandom);
        it.value  = VAL_W'($urandom_range(0, 3));
        it.layer  = 2'($urandom_range(0, 3));
        it.mapped = 1'($urandom);
        it.tgt    = CODE_W'($urandom);
        it.md     = $urandom_range(0, 1) ? '0 : CODE_W'($urandom);
        send(it);
    endtask

    // prefix hold with a handful of keys, occasionally a huge chord so the
    // release run overflows
    task automatic layer_session();
        int                l, n;
        logic [CODE_W-1:0] pk, c;
        l = $urandom_range(0, NUM_LAYERS - 1);
        pk = prefixes[l];
        if (pk == '0) begin
            random_noise();
            return;
        end
        key(pk, VAL_PRS);
        n = ($urandom_range(0, 24) == 0) ? 70 : $urandom_range(0, 5);
        for (int i = 0; i < n; i++) begin
            if (n == 70) begin
                key(CODE_W'(100 + i), VAL_PRS);
            end else begin
                c = pick_code();
                key(c, VAL_PRS);
                if ($urandom_range(0, 2) == 0) begin
                    key(c, VAL_REP);
                end
                if ($urandom_range(0, 3) == 0) begin
                    key(pk, VAL_REP);
                end
                if ($urandom_range(0, 9) == 0) begin
                    random_map();
                end
                if ($urandom_range(0, 4) != 0) begin
                    key(c, VAL_REL);
                end
            end
        end
        if ($urandom_range(0, 9) != 0) begin
            key(pk, VAL_REL);
        end
    endtask

    task automatic random_phase(input int quota);
        int goal;
        goal = items_sent + quota;
        repeat (6) random_map();
        while (items_sent < goal) begin
            if ($urandom_range(0, 7) == 0) begin
                send_quiet = ~send_quiet;
            end
            if ($urandom_range(0, 9) < 7) begin
                layer_session();
            end else begin
                random_noise();
            end
        end
    endtask

    initial begin
        in_ch.valid       = 1'b0;
        in_ch.func        = FUNC_KEY;
        in_ch.key_code    = '0;
        in_ch.key_value   = VAL_REL;
        in_ch.table_layer = '0;
        in_ch.entry_valid = 1'b0;
        in_ch.target_key  = '0;
        in_ch.target_mod  = '0;
        cfg_we            = 1'b0;
        cfg_idx           = REG_PREFIX_0;
        cfg_data          = '0;
        items_sent        = 0;
        send_quiet        = 1'b0;
        long_hold_req     = 1'b0;
        for (int i = 0; i < NUM_LAYERS; i++) begin
            prefixes[i] = '0;
        end
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // layer 3 shares layer 0's prefix, so it must stay dead
        set_prefix(REG_PREFIX_0, 10'd30);
        set_prefix(REG_PREFIX_1, 10'd1023);
        set_prefix(REG_PREFIX_2, 10'd1);
        set_prefix(REG_PREFIX_3, 10'd30);

        // directed part
        map_key(2'd0, 10'd40, 1'b1, 10'd50, 10'd42);     // target with modifier
        map_key(2'd0, 10'd41, 1'b1, 10'd1023, 10'd0);
        map_key(2'd1, 10'd40, 1'b1, 10'd60, 10'd0);
        map_key(2'd3, 10'd40, 1'b1, 10'd70, 10'd0);      // shadowed layer
        map_key(2'd2, 10'd0, 1'b1, 10'd5, 10'd0);
        key(10'd30, VAL_PRS);                            // activate, swallowed
        key(10'd40, VAL_PRS);
        key(10'd40, VAL_REP);
        key(10'd40, VAL_REL);
        key(10'd41, VAL_PRS);
        key(10'd30, VAL_REL);                            // releases held target
        key(10'd30, VAL_PRS);
        key(10'd99, VAL_PRS);                            // unmapped: tap first
        key(10'd99, VAL_REL);
        key(10'd30, VAL_REL);
        key(10'd30, VAL_PRS);
        key(10'd30, VAL_REP);                            // repeat marks used
        key(10'd30, VAL_REL);
        key(10'd30, VAL_PRS);
        key(10'd30, VAL_REL);                            // bare tap
        key(10'd1023, VAL_PRS);
        key(10'd1, VAL_PRS);                             // other prefix inside a layer
        key(10'd1023, VAL_REL);
        key(10'd500, VAL_BAD);                           // ignored value
        key(10'd0, VAL_PRS);
        key(10'd0, VAL_REL);
        drain();

        // duplicate prefixes, extreme code, one layer missing
        set_prefix(REG_PREFIX_0, 10'd0);
        set_prefix(REG_PREFIX_1, 10'd5);
        set_prefix(REG_PREFIX_2, 10'd5);
        set_prefix(REG_PREFIX_3, 10'd1023);
        long_hold_req = 1'b1;                            // back up the pipeline
        random_phase(35);
        key(10'd5, VAL_PRS);                             // leave a layer live
        drain();

        // prefixes move while a layer may still be active
        for (int r = 0; r < NUM_LAYERS; r++) begin
            set_prefix(t_prefix_reg'(r), $urandom_range(0, 3) == 0 ? 10'd0
                       : $urandom_range(0, 1) ? CODE_W'(40 + $urandom_range(0, 7))
                       : CODE_W'($urandom_range(1, KEY_CODES - 1)));
        end
        random_phase(35);
        drain();

        set_prefix(REG_PREFIX_0, 10'd1);
        set_prefix(REG_PREFIX_1, 10'd44);
        set_prefix(REG_PREFIX_2, 10'd1023);
        set_prefix(REG_PREFIX_3, 10'd46);
        random_phase(55);
        drain();

        if (pending != 0) begin
            $error("%0d expected beats never arrived", pending);
        end
        $display("covered %0d input items and %0d output beats over 4 prefix setups",
                 items_sent, beats);
        $display("incl. taps, shadowed layers, modifier wraps and release-run overflow");
        if (fails == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
